// ===== hdl/gcm_pkg.sv =====
`timescale 1ns / 1ps

package gcm_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned FieldW  = 16;
  localparam int unsigned WideW   = 32;

  // input item kinds
  localparam logic [KindW-1:0] KIND_ADD    = 2'd0;
  localparam logic [KindW-1:0] KIND_CHANGE = 2'd1;
  localparam logic [KindW-1:0] KIND_CLEAR  = 2'd2;
  localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;

  // result status codes
  localparam logic [StatusW-1:0] ST_COUNT    = 3'd0;
  localparam logic [StatusW-1:0] ST_CANNOT   = 3'd1;
  localparam logic [StatusW-1:0] ST_ADDED    = 3'd2;
  localparam logic [StatusW-1:0] ST_REJECTED = 3'd3;
  localparam logic [StatusW-1:0] ST_CLEARED  = 3'd4;
  localparam logic [StatusW-1:0] ST_EMPTY    = 3'd5;

endpackage

// ===== hdl/greedy_change_maker.sv =====
`timescale 1ns / 1ps

// greedy coin change over a sorted table of up to MAX_KINDS denominations.
// input item: s_axis_tuser_i is the kind (add, change, clear), s_axis_tdata_i
// the denomination or amount. s_axis_tready_o is high only while the block is
// idle; one item is worked at a time.
// add: the new value is moved into place from the end of the table, each shifted
// entry read and then moved up one slot, then one "added" or "rejected" result.
// clear: one "cleared" result.
// change: each stored denomination goes through the shared restoring divider
// while some amount is left, else it gets a count of zero without it; then
// one "cannot change" result, one "empty" result for an empty table and a zero
// amount, or one count per denomination, the final one with tlast set.
// results leave through an output register, so the sequencer runs ahead while
// one result waits; a stalled receiver (m_axis_tready_i low) holds that
// register and the sequencer waits at its next result.
// reset empties the table and drops any result not yet taken; table contents
// are not cleared, only the fill count.
module greedy_change_maker #(
  parameter int unsigned MAX_KINDS  = 16,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] denomination, [31:16] coin_count
  output logic [2:0]  m_axis_tuser_o,   // [2:0] status
  output logic        m_axis_tlast_o
);

  localparam int unsigned VW = VALUE_BITS;
  localparam int unsigned AW = (MAX_KINDS > 1) ? $clog2(MAX_KINDS) : 1;
  localparam int unsigned UW = $clog2(MAX_KINDS + 1);
  localparam int unsigned FW = gcm_pkg::FieldW;
  localparam int unsigned SW = gcm_pkg::StatusW;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ONE      = 4'd1;
  localparam logic [3:0] S_ADD_RD   = 4'd2;
  localparam logic [3:0] S_ADD_CMP  = 4'd3;
  localparam logic [3:0] S_CHG_RD   = 4'd4;
  localparam logic [3:0] S_CHG_DIV  = 4'd5;
  localparam logic [3:0] S_CHG_WAIT = 4'd6;
  localparam logic [3:0] S_EMIT_RD  = 4'd7;
  localparam logic [3:0] S_EMIT_OUT = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [UW-1:0] used_q, used_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [VW-1:0] value_q, value_d;
  logic [VW-1:0] rest_q, rest_d;
  logic [SW-1:0] res_status_q, res_status_d;
  logic [FW-1:0] res_den_q, res_den_d;

  logic          out_free;
  logic          out_load;
  logic [SW-1:0] out_status;
  logic [FW-1:0] out_den;
  logic [FW-1:0] out_cnt;
  logic          out_last;
  logic          m_valid_q;
  logic [SW-1:0] m_status_q;
  logic [FW-1:0] m_den_q;
  logic [FW-1:0] m_cnt_q;
  logic          m_last_q;

  logic          in_accept;
  logic [gcm_pkg::WideW-1:0] in_wide;
  logic [VW-1:0] in_value;
  logic [gcm_pkg::WideW-1:0] val_wide;
  logic [gcm_pkg::WideW-1:0] rd_wide;
  logic [gcm_pkg::WideW-1:0] quo_wide;

  logic          tbl_we, tbl_re;
  logic [AW-1:0] tbl_waddr, tbl_raddr;
  logic [VW-1:0] tbl_wdata, tbl_rdata;
  logic          cnt_we, cnt_re;
  logic [FW-1:0] cnt_wdata, cnt_rdata;

  logic          div_start, div_done;
  logic [VW-1:0] div_quo, div_rem;
  logic          idx_last;

  assign in_wide  = gcm_pkg::WideW'(s_axis_tdata_i);
  assign in_value = in_wide[VW-1:0];
  assign val_wide = gcm_pkg::WideW'(value_q);
  assign rd_wide  = gcm_pkg::WideW'(tbl_rdata);
  assign quo_wide = gcm_pkg::WideW'(div_quo);

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign idx_last = (UW'(idx_q) + UW'(1)) == used_q;

  gcm_ram #(.Width(VW), .Depth(MAX_KINDS)) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .re_i   (tbl_re),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  gcm_ram #(.Width(FW), .Depth(MAX_KINDS)) u_counts (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(idx_q),
    .wdata_i(cnt_wdata),
    .re_i   (cnt_re),
    .raddr_i(idx_q),
    .rdata_o(cnt_rdata)
  );

  gcm_div #(.Width(VW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rest_q),
    .divisor_i  (tbl_rdata),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    idx_d        = idx_q;
    value_d      = value_q;
    rest_d       = rest_q;
    res_status_d = res_status_q;
    res_den_d    = res_den_q;
    tbl_we       = 1'b0;
    tbl_waddr    = idx_q;
    tbl_wdata    = value_q;
    tbl_re       = 1'b0;
    tbl_raddr    = idx_q;
    cnt_we       = 1'b0;
    cnt_wdata    = '0;
    cnt_re       = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    out_status   = res_status_q;
    out_den      = res_den_q;
    out_cnt      = '0;
    out_last     = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          value_d   = in_value;
          rest_d    = in_value;
          idx_d     = '0;
          res_den_d = '0;
          state_d   = S_ONE;
          unique case (s_axis_tuser_i)
            gcm_pkg::KIND_ADD: begin
              if (in_value == '0 || used_q == UW'(MAX_KINDS)) begin
                res_status_d = gcm_pkg::ST_REJECTED;
              end else begin
                idx_d   = used_q[AW-1:0];
                state_d = S_ADD_RD;
              end
            end
            gcm_pkg::KIND_CHANGE: begin
              if (used_q != '0) begin
                state_d = S_CHG_RD;
              end else if (in_value == '0) begin
                res_status_d = gcm_pkg::ST_EMPTY;
              end else begin
                res_status_d = gcm_pkg::ST_CANNOT;
              end
            end
            gcm_pkg::KIND_CLEAR: begin
              used_d       = '0;
              res_status_d = gcm_pkg::ST_CLEARED;
            end
            gcm_pkg::KIND_UNUSED: begin
              res_status_d = gcm_pkg::ST_REJECTED;
            end
            default: begin
              res_status_d = gcm_pkg::ST_REJECTED;
            end
          endcase
        end
      end

      S_ONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // insertion walks down from the end, moving smaller entries up one slot
      S_ADD_RD: begin
        if (idx_q == '0) begin
          tbl_we       = 1'b1;
          used_d       = used_q + UW'(1);
          res_status_d = gcm_pkg::ST_ADDED;
          res_den_d    = val_wide[FW-1:0];
          state_d      = S_ONE;
        end else begin
          tbl_re    = 1'b1;
          tbl_raddr = idx_q - AW'(1);
          state_d   = S_ADD_CMP;
        end
      end

      S_ADD_CMP: begin
        tbl_we = 1'b1;
        if (tbl_rdata < value_q) begin
          tbl_wdata = tbl_rdata;
          idx_d     = idx_q - AW'(1);
          state_d   = S_ADD_RD;
        end else begin
          used_d       = used_q + UW'(1);
          res_status_d = gcm_pkg::ST_ADDED;
          res_den_d    = val_wide[FW-1:0];
          state_d      = S_ONE;
        end
      end

      S_CHG_RD: begin
        tbl_re  = 1'b1;
        state_d = S_CHG_DIV;
      end

      S_CHG_DIV: begin
        if (rest_q == '0 || tbl_rdata == '0) begin
          // nothing left to split: zero pieces of this denomination
          cnt_we = 1'b1;
          if (idx_last) begin
            idx_d   = '0;
            state_d = S_EMIT_RD;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_CHG_RD;
          end
        end else begin
          div_start = 1'b1;
          state_d   = S_CHG_WAIT;
        end
      end

      S_CHG_WAIT: begin
        if (div_done) begin
          cnt_we    = 1'b1;
          cnt_wdata = quo_wide[FW-1:0];
          rest_d    = div_rem;
          if (!idx_last) begin
            idx_d   = idx_q + AW'(1);
            state_d = S_CHG_RD;
          end else if (div_rem != '0) begin
            res_status_d = gcm_pkg::ST_CANNOT;
            state_d      = S_ONE;
          end else begin
            idx_d   = '0;
            state_d = S_EMIT_RD;
          end
        end
      end

      S_EMIT_RD: begin
        tbl_re  = 1'b1;
        cnt_re  = 1'b1;
        state_d = S_EMIT_OUT;
      end

      S_EMIT_OUT: begin
        out_status = gcm_pkg::ST_COUNT;
        out_den    = rd_wide[FW-1:0];
        out_cnt    = cnt_rdata;
        out_last   = idx_last;
        if (out_free) begin
          out_load = 1'b1;
          if (idx_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q      <= value_d;
    rest_q       <= rest_d;
    res_status_q <= res_status_d;
    res_den_q    <= res_den_d;
    if (out_load) begin
      m_status_q <= out_status;
      m_den_q    <= out_den;
      m_cnt_q    <= out_cnt;
      m_last_q   <= out_last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_cnt_q, m_den_q};
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tlast_o  = m_last_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(MAX_KINDS))
    else $error("table fill count above capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready_i))
    else $error("output register overwritten while holding an item");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_CHG_WAIT))
    else $error("divider finished outside of a change request");

  a_start_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == S_CHG_WAIT && !div_done))
    else $error("divider started but sequencer not waiting");

endmodule

// ===== hdl/gcm_ram.sv =====
`timescale 1ns / 1ps

module gcm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/gcm_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module gcm_div #(
  parameter int unsigned Width = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quotient_o,
  output logic [Width-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] quo_q, quo_d;
  logic [Width-1:0] dvs_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [Width:0]   shifted;
  logic [Width:0]   diff;

  assign shifted = {rem_q, quo_q[Width-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CntW'(Width);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // borrow out means the trial subtraction failed
      if (!diff[Width]) begin
        rem_d = diff[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = shifted[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
